// ===== rtl/core/stable_record_merge_sort_macros.svh =====
// Assertion macros shared by the record sorter RTL.
`ifndef STABLE_RECORD_MERGE_SORT_MACROS_SVH
`define STABLE_RECORD_MERGE_SORT_MACROS_SVH

// Condition and consequence checked in the same cycle.
`define SRMS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequence checked in the cycle after the condition.
`define SRMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/srms_pkg.sv =====
// Shared constants and types of the stable record sorter.
package srms_pkg;

   localparam int MaxRecords = 64;
   localparam int AddrW      = $clog2(MaxRecords);
   localparam int CntW       = $clog2(MaxRecords + 1);
   localparam int SumW       = CntW + 1;
   localparam int KeyW       = 32;
   localparam int IdxW       = 6;

   typedef logic [AddrW-1:0] addr_type;
   typedef logic [CntW-1:0]  cnt_type;
   typedef logic [SumW-1:0]  sum_type;
   typedef logic [IdxW-1:0]  idx_type;

   // One stored record: key, payload and arrival position
   typedef struct packed {
      logic signed [KeyW-1:0] key;
      logic signed [KeyW-1:0] slope;
      idx_type                idx;
   } rec_type;

   // Write port bundle of a record bank
   typedef struct packed {
      logic     en;
      addr_type addr;
      rec_type  data;
   } wr_type;

endpackage

// ===== rtl/core/srms_chan_if.sv =====
// Valid/ready channel interfaces for record input and sorted output.
interface srms_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [srms_pkg::KeyW-1:0]     intercept_key;
   logic signed [srms_pkg::KeyW-1:0]     slope_value;
   logic                                 is_final;

   modport source (output valid, intercept_key, slope_value, is_final, input ready);
   modport sink   (input valid, intercept_key, slope_value, is_final, output ready);
endinterface

interface srms_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [srms_pkg::KeyW-1:0]     sorted_key;
   logic signed [srms_pkg::KeyW-1:0]     sorted_slope;
   srms_pkg::idx_type                    arrival_index;
   logic                                 end_of_run;
   logic                                 overflow;

   modport source (output valid, sorted_key, sorted_slope, arrival_index, end_of_run,
                   overflow, input ready);
   modport sink   (input valid, sorted_key, sorted_slope, arrival_index, end_of_run,
                   overflow, output ready);
endinterface

// ===== rtl/core/stable_record_merge_sort.sv =====
// Stable record sorter: loads records, merge sorts them by key, streams them out.
//
// req_chan takes one record per transfer (key, slope, is_final). Records are
// loaded at one per cycle into a bank; arrival position is kept with each one.
// Records past MaxRecords are dropped and flag overflow on the whole run.
// The transfer with is_final set closes the set and starts the sort; req_chan
// then stays not ready until the last sorted record is in the output register.
// Sorting is a bottom-up merge between two ping-pong banks driven by one key
// comparator over ceil(log2 n) passes; every merged record goes through a read
// state and a compare/write state on the shared bank ports. Equal keys take
// the left run first, so order is stable. Emission reads each record from the
// bank, then loads it into the output register; end_of_run marks the last
// record. The output register decouples rsp_chan: a stalled receiver holds the
// current result and pauses the read sequencer, and a new set may start loading
// while the last result still waits. Synchronous reset empties the set, clears
// the overflow flag and the valid flag of the output register; bank contents
// are not cleared.
`include "stable_record_merge_sort_macros.svh"

module stable_record_merge_sort (
   input logic          clock,
   input logic          reset,
   srms_req_if.sink     req_chan,
   srms_rsp_if.source   rsp_chan
);

   localparam srms_pkg::cnt_type CntFull = srms_pkg::cnt_type'(srms_pkg::MaxRecords);
   localparam srms_pkg::cnt_type CntOne  = srms_pkg::cnt_type'(1);
   localparam srms_pkg::sum_type SumOne  = srms_pkg::sum_type'(1);

   typedef enum logic [5:0] {
      ST_LOAD    = 6'b000001,
      ST_PAIR    = 6'b000010,
      ST_READ    = 6'b000100,
      ST_MERGE   = 6'b001000,
      ST_EMIT_RD = 6'b010000,
      ST_EMIT_WR = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   srms_pkg::cnt_type    cnt_ff, cnt_in, cnt_nx;
   logic                 drop_ff, drop_in;
   srms_pkg::cnt_type    n_ff, n_in;
   srms_pkg::cnt_type    e_ff, e_in;
   srms_pkg::sum_type    w_ff, w_in;
   srms_pkg::sum_type    base_ff, base_in;
   srms_pkg::sum_type    lend_ff, lend_in;
   srms_pkg::sum_type    rend_ff, rend_in;
   srms_pkg::sum_type    i_ff, i_in;
   srms_pkg::sum_type    j_ff, j_in;
   srms_pkg::sum_type    k_ff, k_in;
   logic                 src_ff, src_in;
   logic                 out_valid_ff, out_valid_in;
   srms_pkg::rec_type    out_rec_ff, out_rec_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_ovf_ff, out_ovf_in;

   logic                 req_xfer;
   logic                 rsp_xfer;
   logic                 out_free;
   logic                 take_left;
   srms_pkg::sum_type    n_sum;
   srms_pkg::sum_type    w_dbl;
   srms_pkg::sum_type    lo_sum;
   srms_pkg::sum_type    hi_sum;
   srms_pkg::sum_type    lo_end;
   srms_pkg::sum_type    hi_end;
   srms_pkg::addr_type   raddr_a;
   srms_pkg::addr_type   raddr_b;
   srms_pkg::rec_type    b0_rd_a, b0_rd_b, b1_rd_a, b1_rd_b;
   srms_pkg::rec_type    rd_a, rd_b;
   srms_pkg::rec_type    merge_rec;
   srms_pkg::wr_type     wr0, wr1;

   // ping-pong record banks
   srms_bank u_bank0 (
      .clock     (clock),
      .wr        (wr0),
      .rd_addr_a (raddr_a),
      .rd_addr_b (raddr_b),
      .rd_data_a (b0_rd_a),
      .rd_data_b (b0_rd_b)
   );

   srms_bank u_bank1 (
      .clock     (clock),
      .wr        (wr1),
      .rd_addr_a (raddr_a),
      .rd_addr_b (raddr_b),
      .rd_data_a (b1_rd_a),
      .rd_data_b (b1_rd_b)
   );

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_xfer = out_valid_ff && rsp_chan.ready;
   assign out_free = !out_valid_ff || rsp_xfer;

   assign rd_a = src_ff ? b1_rd_a : b0_rd_a;
   assign rd_b = src_ff ? b1_rd_b : b0_rd_b;

   // run bounds of the next pair of runs
   assign n_sum  = srms_pkg::sum_type'(n_ff);
   assign w_dbl  = w_ff << 1;
   assign lo_sum = base_ff + w_ff;
   assign hi_sum = base_ff + w_dbl;
   assign lo_end = (lo_sum < n_sum) ? lo_sum : n_sum;
   assign hi_end = (hi_sum < n_sum) ? hi_sum : n_sum;

   // shared key comparator: left wins on less-or-equal
   assign take_left = (i_ff < lend_ff) && ((j_ff >= rend_ff) || (rd_a.key <= rd_b.key));
   assign merge_rec = take_left ? rd_a : rd_b;

   assign cnt_nx = (cnt_ff < CntFull) ? cnt_ff + CntOne : cnt_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      drop_in      = drop_ff;
      n_in         = n_ff;
      e_in         = e_ff;
      w_in         = w_ff;
      base_in      = base_ff;
      lend_in      = lend_ff;
      rend_in      = rend_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      src_in       = src_ff;
      out_valid_in = out_valid_ff && !rsp_xfer;
      out_rec_in   = out_rec_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      raddr_a      = srms_pkg::addr_type'(i_ff);
      raddr_b      = srms_pkg::addr_type'(j_ff);
      wr0          = '{en: 1'b0, addr: srms_pkg::addr_type'(k_ff), data: merge_rec};
      wr1          = '{en: 1'b0, addr: srms_pkg::addr_type'(k_ff), data: merge_rec};

      unique case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               if (cnt_ff < CntFull) begin
                  wr0.en         = 1'b1;
                  wr0.addr       = srms_pkg::addr_type'(cnt_ff);
                  wr0.data.key   = req_chan.intercept_key;
                  wr0.data.slope = req_chan.slope_value;
                  wr0.data.idx   = srms_pkg::idx_type'(cnt_ff);
               end else begin
                  drop_in = 1'b1;
               end
               cnt_in = cnt_nx;
               if (req_chan.is_final) begin
                  n_in    = cnt_nx;
                  e_in    = '0;
                  w_in    = SumOne;
                  base_in = '0;
                  src_in  = 1'b0;
                  state_in = (cnt_nx > CntOne) ? ST_PAIR : ST_EMIT_RD;
               end
            end
         end
         ST_PAIR: begin
            if (base_ff >= n_sum) begin
               // pass done: double run width and swap banks
               w_in    = w_dbl;
               src_in  = !src_ff;
               base_in = '0;
               state_in = (w_dbl >= n_sum) ? ST_EMIT_RD : ST_PAIR;
            end else begin
               lend_in  = lo_end;
               rend_in  = hi_end;
               i_in     = base_ff;
               j_in     = lo_end;
               k_in     = base_ff;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (src_ff) begin
               wr0.en = 1'b1;
            end else begin
               wr1.en = 1'b1;
            end
            if (take_left) begin
               i_in = i_ff + SumOne;
            end else begin
               j_in = j_ff + SumOne;
            end
            k_in = k_ff + SumOne;
            if (k_ff + SumOne == rend_ff) begin
               base_in  = rend_ff;
               state_in = ST_PAIR;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_EMIT_RD: begin
            raddr_a = srms_pkg::addr_type'(e_ff);
            if (out_free) begin
               state_in = ST_EMIT_WR;
            end
         end
         ST_EMIT_WR: begin
            out_valid_in = 1'b1;
            out_rec_in   = rd_a;
            out_last_in  = (e_ff == n_ff - CntOne);
            out_ovf_in   = drop_ff;
            e_in         = e_ff + CntOne;
            if (e_ff == n_ff - CntOne) begin
               cnt_in   = '0;
               drop_in  = 1'b0;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         drop_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         drop_ff      <= drop_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // sequencer datapath and output payload
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      e_ff        <= e_in;
      w_ff        <= w_in;
      base_ff     <= base_in;
      lend_ff     <= lend_in;
      rend_ff     <= rend_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      src_ff      <= src_in;
      out_rec_ff  <= out_rec_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign req_chan.ready        = (state_ff == ST_LOAD);
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.sorted_key   = out_rec_ff.key;
   assign rsp_chan.sorted_slope = out_rec_ff.slope;
   assign rsp_chan.arrival_index = out_rec_ff.idx;
   assign rsp_chan.end_of_run   = out_last_ff;
   assign rsp_chan.overflow     = out_ovf_ff;

   // checks
   `SRMS_ASSERT_SAME(a_cnt_cap, clock, reset, 1'b1, cnt_ff <= CntFull,
      "record count over capacity")
   `SRMS_ASSERT_SAME(a_merge_bound, clock, reset, state_ff == ST_MERGE, k_ff < rend_ff,
      "merge ran past its run pair")
   `SRMS_ASSERT_SAME(a_out_free, clock, reset, state_ff == ST_EMIT_WR, !out_valid_ff,
      "output register overwritten")
   `SRMS_ASSERT_NEXT(a_final_busy, clock, reset, req_xfer && req_chan.is_final,
      !req_chan.ready, "input taken after final record")
   `SRMS_ASSERT_SAME(a_drop_full, clock, reset, !drop_ff && drop_in, cnt_ff == CntFull,
      "record dropped below capacity")

endmodule

// ===== rtl/core/srms_bank.sv =====
// Record bank: one write port, two read ports with registered read data.
module srms_bank (
   input  logic              clock,
   input  srms_pkg::wr_type  wr,
   input  srms_pkg::addr_type rd_addr_a,
   input  srms_pkg::addr_type rd_addr_b,
   output srms_pkg::rec_type rd_data_a,
   output srms_pkg::rec_type rd_data_b
);

   srms_pkg::rec_type mem [srms_pkg::MaxRecords];
   srms_pkg::rec_type rd_a_ff;
   srms_pkg::rec_type rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // registered read ports
   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== tb/srms_sort_checker.sv =====
// Scoreboard for the record sorter: predicts each sorted run and checks every result.
module srms_sort_checker (
   input  logic clock,
   input  logic reset,
   srms_req_if  req_mon,
   srms_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import srms_pkg::*;

   // One expected result: the record plus its run markers
   typedef struct packed {
      rec_type rec;
      logic    last;
      logic    dropped;
   } sorted_line_type;

   rec_type         line_bank [MaxRecords];
   int unsigned     lines_held = 0;
   logic            lines_dropped = 1'b0;
   sorted_line_type awaited_lines [$];
   int              mismatches = 0;

   task automatic compare_field(input string field, input logic [KeyW-1:0] want,
                                input logic [KeyW-1:0] got);
      if (got !== want) begin
         mismatches++;
         $error("%s: expected %h, actual %h", field, want, got);
      end
   endtask

   // Stable ascending sort of the held set: a record moves left only past
   // strictly greater keys, so equal keys keep arrival order.
   task automatic release_sorted_set();
      rec_type         moving;
      int unsigned     i;
      int unsigned     j;
      sorted_line_type entry;
      for (i = 1; i < lines_held; i++) begin
         moving = line_bank[i];
         j = i;
         while (j > 0 && $signed(line_bank[j-1].key) > $signed(moving.key)) begin
            line_bank[j] = line_bank[j-1];
            j--;
         end
         line_bank[j] = moving;
      end
      for (i = 0; i < lines_held; i++) begin
         entry.rec     = line_bank[i];
         entry.last    = (i + 1 == lines_held);
         entry.dropped = lines_dropped;
         awaited_lines.push_back(entry);
      end
      lines_held    = 0;
      lines_dropped = 1'b0;
   endtask

   always @(posedge clock) begin
      sorted_line_type head;
      if (reset) begin
         lines_held    = 0;
         lines_dropped = 1'b0;
         awaited_lines.delete();
      end else begin
         // Result transfer: compare against the oldest expected record
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_lines.size() == 0) begin
               mismatches++;
               $error("result transfer with no sorted record outstanding");
            end else begin
               head = awaited_lines.pop_front();
               compare_field("sorted_key", head.rec.key, rsp_mon.sorted_key);
               compare_field("sorted_slope", head.rec.slope, rsp_mon.sorted_slope);
               compare_field("arrival_index", head.rec.idx, rsp_mon.arrival_index);
               compare_field("end_of_run", head.last, rsp_mon.end_of_run);
               compare_field("overflow", head.dropped, rsp_mon.overflow);
            end
         end
         // Record transfer: load or drop, then close the set on the final one
         if (req_mon.valid && req_mon.ready) begin
            if (lines_held < MaxRecords) begin
               line_bank[lines_held] = '{key:   req_mon.intercept_key,
                                         slope: req_mon.slope_value,
                                         idx:   idx_type'(lines_held)};
               lines_held++;
            end else begin
               lines_dropped = 1'b1;
            end
            if (req_mon.is_final)
               release_sorted_set();
         end
      end
      fail_count    <= mismatches;
      pending_count <= awaited_lines.size();
   end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the record sorter: clock, reset, record stimulus and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import srms_pkg::*;

   localparam int CycleLimit  = 200000;
   localparam int HoldCycles  = 400;
   localparam int DrainCycles = 100;
   localparam int RandomSets  = 14;

   localparam logic signed [KeyW-1:0] KeyMin = {1'b1, {(KeyW-1){1'b0}}};
   localparam logic signed [KeyW-1:0] KeyMax = {1'b0, {(KeyW-1){1'b1}}};
   localparam logic signed [KeyW-1:0] QOne   = 32'sh0001_0000;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   fail_count;
   int   pending_count;
   logic calm = 1'b0;
   logic hold_request = 1'b0;

   srms_req_if req_chan ();
   srms_rsp_if rsp_chan ();

   stable_record_merge_sort dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   srms_sort_checker order_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: random stalls, none while calm, and one long hold-off on request
   initial begin
      int hold_left;
      bit hold_used;
      hold_left = 0;
      hold_used = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= calm || ($urandom_range(0, 99) >= 36);
         end
      end
   end

   // Keys: extremes, small Q16.16 values that collide often, or anything
   function automatic logic signed [KeyW-1:0] pick_key();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         case ($urandom_range(0, 3))
            0: return KeyMin;
            1: return KeyMax;
            2: return '0;
            default: return '1;
         endcase
      end
      if (sel < 5)
         return ($signed(KeyW'($urandom_range(0, 6))) - 3) * QOne;
      return $urandom();
   endfunction

   // One record transfer, with random idle cycles ahead of it unless calm
   task automatic push_record(input logic signed [KeyW-1:0] key,
                              input logic signed [KeyW-1:0] slope,
                              input logic last_flag);
      while (!calm && $urandom_range(0, 99) < 36) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.intercept_key <= key;
      req_chan.slope_value   <= slope;
      req_chan.is_final      <= last_flag;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic push_random_set(input int count);
      for (int n = 0; n < count; n++)
         push_record(pick_key(), $urandom(), n == count - 1);
   endtask

   // Stop offering and wait for every predicted result to come back
   task automatic wait_for_empty();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int set_size;
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.intercept_key <= '0;
      req_chan.slope_value   <= '0;
      req_chan.is_final      <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Single-record set
      push_record(KeyMax, KeyMin, 1'b1);
      // Extremes, sign boundary and repeated extremes
      push_record(KeyMax, 1, 1'b0);
      push_record(KeyMin, KeyMax, 1'b0);
      push_record('0, KeyMin, 1'b0);
      push_record(-1, '0, 1'b0);
      push_record(1, -1, 1'b0);
      push_record(KeyMin, 2, 1'b0);
      push_record(KeyMax, 3, 1'b0);
      push_record('0, 4, 1'b1);
      // All keys equal: arrival order must survive
      for (int n = 0; n < 5; n++)
         push_record(QOne, n + 1, n == 4);
      // Descending keys with a tie
      push_record(3 * QOne, 10, 1'b0);
      push_record(2 * QOne, 11, 1'b0);
      push_record(2 * QOne, 12, 1'b0);
      push_record(-QOne, 13, 1'b1);

      // Random sets: one full set, one past capacity, the rest small
      for (int s = 0; s < RandomSets; s++) begin
         if (s == 2) calm <= 1'b1;
         if (s == 4) calm <= 1'b0;
         if (s == 9) hold_request <= 1'b1;
         if (s == 2)
            set_size = MaxRecords;
         else if (s == 5)
            set_size = MaxRecords + 3;
         else
            set_size = $urandom_range(1, 9);
         push_random_set(set_size);
         if (s == 3) wait_for_empty();
      end

      wait_for_empty();
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
